### rtl/f2h_pkg.sv
`default_nettype none
package f2h_pkg;

  typedef struct packed {
    logic [31:0] single_bits;
    logic        last_in;
  } f2h_in_t;

  typedef struct packed {
    logic [15:0] half_bits;
    logic        saturated;
    logic        is_nan;
    logic        last_out;
  } f2h_out_t;

  localparam logic [30:0] HalfMaxMag   = 31'h477F_E000;
  localparam logic [14:0] HalfMaxFinite = 15'h7BFF;

endpackage
`default_nettype wire

### rtl/float32_to_float16_saturating_top.sv
`default_nettype none
// float32 to float16 converter, saturating, round to nearest even
//
// input channel: an item (in_data) is taken at a clock edge where in_start
// is high and in_busy is low; in_busy is tied low, so one item may enter
// every cycle
// result channel: out_strobe is high for exactly one cycle with out_data;
// the receiver cannot stall, so there is no backpressure path
// the result is registered in stage 1, stage 2 and stage 3 after the accept edge
// throughput: one item per clock; there are three register stages
//   stage 1: classify (nan, saturate, zero), compute shift amount
//   stage 2: shift mantissa, form quotient and sticky/round bits
//   stage 3: round increment, sign merge
// reset: rst_n low clears the stage valid bits; no item is in flight after
// nan keeps the sign and mantissa bits 21..13 with the quiet bit set
module float32_to_float16_saturating_top
  import f2h_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_start,
  output logic          in_busy,
  input  wire f2h_in_t  in_data,
  output logic          out_strobe,
  output f2h_out_t      out_data
);

  assign in_busy = 1'b0;

  // stage 1 registers
  logic        v1_r;
  logic        sign1_r, last1_r, nan1_r, sat1_r, zero1_r, norm1_r;
  logic [9:0]  nanman1_r;
  logic [23:0] full1_r;
  logic [4:0]  he1_r;
  logic [4:0]  shift1_r;   // shift - 13, 0..18

  logic [7:0]  exp_w;
  logic [22:0] man_w;
  logic signed [9:0] he_w;
  logic [9:0]  s_w;

  always_comb begin
    exp_w = in_data.single_bits[30:23];
    man_w = in_data.single_bits[22:0];
    he_w  = $signed({2'b00, exp_w}) - 10'sd112;
    s_w   = 10'd14 - he_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_start;
    end
    sign1_r   <= in_data.single_bits[31];
    last1_r   <= in_data.last_in;
    nan1_r    <= (exp_w == 8'hFF) && (man_w != 23'd0);
    sat1_r    <= !((exp_w == 8'hFF) && (man_w != 23'd0)) &&
                 (in_data.single_bits[30:0] > HalfMaxMag);
    zero1_r   <= (exp_w == 8'd0) || (!(he_w >= 10'sd1) && (s_w > 10'd31));
    norm1_r   <= he_w >= 10'sd1;
    nanman1_r <= {1'b1, man_w[21:13]};
    full1_r   <= {1'b1, man_w};
    he1_r     <= he_w[4:0];
    shift1_r  <= (he_w >= 10'sd1) ? 5'd0 : 5'(s_w - 10'd13);
  end

  // stage 2: shift and round bits
  logic        v2_r;
  logic        sign2_r, last2_r, nan2_r, sat2_r, zero2_r, norm2_r;
  logic [9:0]  nanman2_r;
  logic [4:0]  he2_r;
  logic [10:0] q2_r;
  logic        rbit2_r, sticky2_r;

  logic [41:0] sh_w;
  always_comb sh_w = {full1_r, 18'd0} >> shift1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    sign2_r   <= sign1_r;
    last2_r   <= last1_r;
    nan2_r    <= nan1_r;
    sat2_r    <= sat1_r;
    zero2_r   <= zero1_r;
    norm2_r   <= norm1_r;
    nanman2_r <= nanman1_r;
    he2_r     <= he1_r;
    q2_r      <= sh_w[41:31];
    rbit2_r   <= sh_w[30];
    sticky2_r <= |sh_w[29:0];
  end

  // stage 3: increment and merge
  logic        v3_r;
  f2h_out_t    out3_r;
  logic [14:0] base_w, mag_w;

  always_comb begin
    base_w = norm2_r ? {he2_r, q2_r[9:0]} : {4'd0, q2_r};
    if (rbit2_r && (sticky2_r || q2_r[0])) base_w = base_w + 15'd1;
    if (nan2_r) mag_w = {5'h1F, nanman2_r};
    else if (sat2_r) mag_w = HalfMaxFinite;
    else if (zero2_r) mag_w = 15'd0;
    else mag_w = base_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    out3_r.half_bits <= {sign2_r, mag_w};
    out3_r.saturated <= sat2_r;
    out3_r.is_nan    <= nan2_r;
    out3_r.last_out  <= last2_r;
  end

  assign out_strobe = v3_r;
  assign out_data   = out3_r;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_start |-> ##3 out_strobe) else $error("result lost");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_data.saturated && out_data.is_nan)) else $error("flag clash");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.saturated) |-> (out_data.half_bits[14:0] == HalfMaxFinite))
    else $error("bad saturation");

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`default_nettype none
module tb_top;
  import f2h_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_start = 1'b0;
  logic     in_busy;
  f2h_in_t  in_data = '0;
  logic     out_strobe;
  f2h_out_t out_data;

  // pending conversions, oldest first
  f2h_out_t half_queue[$];
  int       fail_count = 0;

  float32_to_float16_saturating_top dut (
    .clk(clk), .rst_n(rst_n), .in_start(in_start), .in_busy(in_busy),
    .in_data(in_data), .out_strobe(out_strobe), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // rounds a binary32 magnitude to a binary16 magnitude, nearest even
  function automatic logic [14:0] round_to_half(input logic [7:0] exp8,
                                                input logic [22:0] man23);
    logic [23:0] full;
    int          he;
    int          shift;
    logic [23:0] q;
    logic [23:0] rem;
    logic [23:0] halfway;
    logic [15:0] base;
    full = {1'b1, man23};
    he = int'(exp8) - 112;
    if (he >= 1) begin
      shift = 13;
    end else begin
      shift = 14 - he;
      if (shift > 31) return '0;
    end
    if (shift > 24) return '0; // everything below the round point
    q = full >> shift;
    rem = full & ((24'd1 << shift) - 24'd1);
    halfway = 24'd1 << (shift - 1);
    if (he >= 1) base = {he[5:0], q[9:0]};
    else base = q[15:0];
    if (rem > halfway || (rem == halfway && q[0])) base = base + 16'd1;
    return base[14:0];
  endfunction

  function automatic f2h_out_t convert_single(input f2h_in_t item);
    f2h_out_t    r;
    logic [7:0]  exp8;
    logic [22:0] man;
    logic [14:0] mag;
    exp8 = item.single_bits[30:23];
    man = item.single_bits[22:0];
    r = '0;
    if (exp8 == 8'hFF && man != 0) begin
      r.is_nan = 1'b1;
      mag = {5'h1F, 1'b1, man[21:13]};
    end else if (item.single_bits[30:0] > HalfMaxMag) begin
      r.saturated = 1'b1;
      mag = HalfMaxFinite;
    end else if (exp8 == 8'h00) begin
      mag = '0;
    end else begin
      mag = round_to_half(exp8, man);
    end
    r.half_bits = {item.single_bits[31], mag};
    r.last_out = item.last_in;
    return r;
  endfunction

  // directed rows: input word and, where obvious, the expected half
  typedef struct {
    logic [31:0] word;
    logic        known;
    logic [15:0] half;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{32'h0000_0000, 1'b1, 16'h0000},  // +zero
    '{32'h8000_0000, 1'b1, 16'h8000},  // -zero
    '{32'h0000_0001, 1'b1, 16'h0000},  // single subnormal
    '{32'h807F_FFFF, 1'b1, 16'h8000},  // negative single subnormal
    '{32'h7F80_0000, 1'b1, 16'h7BFF},  // +inf saturates
    '{32'hFF80_0000, 1'b1, 16'hFBFF},  // -inf saturates
    '{32'h7F7F_FFFF, 1'b1, 16'h7BFF},  // largest single
    '{32'h477F_E000, 1'b1, 16'h7BFF},  // exactly 65504, no flag
    '{32'h477F_E001, 1'b1, 16'h7BFF},  // just above 65504
    '{32'h477F_EFFF, 1'b1, 16'h7BFF},  // just under 65520
    '{32'h7FC0_0000, 1'b1, 16'h7E00},  // quiet nan
    '{32'hFF80_0001, 1'b1, 16'hFE00},  // signaling nan, low bits lost
    '{32'h7FFF_FFFF, 1'b1, 16'h7FFF},  // nan all ones
    '{32'h3F80_0000, 1'b1, 16'h3C00},  // 1.0
    '{32'h3F80_1000, 1'b0, 16'h0},     // tie, round to even
    '{32'h3F80_3000, 1'b0, 16'h0},     // tie, round up
    '{32'h3880_0000, 1'b1, 16'h0400},  // smallest normal half
    '{32'h3380_0000, 1'b1, 16'h0001},  // smallest half subnormal
    '{32'h3300_0000, 1'b1, 16'h0000},  // half of it, tie to zero
    '{32'h3300_0001, 1'b0, 16'h0},     // just above that tie
    '{32'h387F_FFFF, 1'b0, 16'h0},     // subnormal rounding into normal
    '{32'h0080_0000, 1'b1, 16'h0000},  // smallest single normal
    '{32'hB3C0_0000, 1'b0, 16'h0},     // negative tiny tie
    '{32'h477F_DFFF, 1'b0, 16'h0}      // just below max
  };

  // accept one item: hold start until an edge with busy low
  task automatic send_item(input logic [31:0] word, input logic last,
                           input logic known, input logic [15:0] half);
    f2h_in_t item;
    f2h_out_t want;
    item.single_bits = word;
    item.last_in = last;
    in_data <= item;
    in_start <= 1'b1;
    do @(posedge clk); while (in_busy);
    want = convert_single(item);
    if (known && want.half_bits !== half) begin
      $error("half_bits table: expected %h actual %h", half, want.half_bits);
      fail_count++;
    end
    if (known) want.half_bits = half;
    half_queue.push_back(want);
    @(negedge clk);
  endtask

  task automatic idle_burst();
    in_start <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  // result checker, samples at the rising edge
  always @(posedge clk) begin
    f2h_out_t want;
    if (rst_n && out_strobe) begin
      if (half_queue.size() == 0) begin
        $error("unexpected result %h", out_data);
        fail_count++;
      end else begin
        want = half_queue.pop_front();
        if (out_data.half_bits !== want.half_bits) begin
          $error("half_bits: expected %h actual %h", want.half_bits, out_data.half_bits);
          fail_count++;
        end
        if (out_data.saturated !== want.saturated) begin
          $error("saturated: expected %b actual %b", want.saturated, out_data.saturated);
          fail_count++;
        end
        if (out_data.is_nan !== want.is_nan) begin
          $error("is_nan: expected %b actual %b", want.is_nan, out_data.is_nan);
          fail_count++;
        end
        if (out_data.last_out !== want.last_out) begin
          $error("last_out: expected %b actual %b", want.last_out, out_data.last_out);
          fail_count++;
        end
      end
    end
  end

  // random word biased toward the interesting exponent bands
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    logic [7:0]  e;
    w = $urandom();
    case ($urandom_range(0, 7))
      0: e = 8'hFF;                                 // inf / nan
      1: e = 8'h00;                                 // zero / subnormal
      2: e = 8'(8'd102 + $urandom_range(0, 11));    // half subnormal band and the smallest normal
      3: e = 8'(8'd142 + $urandom_range(0, 2));     // near saturation
      4: e = 8'(8'd113 + $urandom_range(0, 29));    // normal halves
      default: e = w[30:23];
    endcase
    w[30:23] = e;
    // sometimes land exactly on a rounding tie
    if ($urandom_range(0, 3) == 0) w[12:0] = 13'h1000;
    return w;
  endfunction

  initial begin
    int n;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].word, 1'(i == dir_rows.size() - 1),
                dir_rows[i].known, dir_rows[i].half);

    n = 0;
    while (n < 1050) begin
      // idling only in the first part of the run
      if (n < 850 && $urandom_range(0, 5) == 0) idle_burst();
      send_item(random_word(), 1'($urandom_range(0, 1)), 1'b0, 16'h0);
      n++;
    end
    in_start <= 1'b0;

    while (half_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("float32_to_float16_saturating_top regression: pass");
    end else begin
      $display("float32_to_float16_saturating_top regression: fail");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("float32_to_float16_saturating_top regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
